// ----- hw/rtl/pfrm_pkg.sv -----
// Shared types and constants of the PCM frame RMS and peak-to-peak meter.
package pfrm_pkg;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_LENGTH = 16'd1600;
  localparam logic [CFG_DATA_W-1:0] RST_WINDOW_LEN   = 16'd1024;

  // Payload widths.
  localparam int RAW_W    = 32;
  localparam int SAMPLE_W = 20;
  localparam int SCALED_W = 16;
  localparam int IDX_W    = 16;
  localparam int LEVEL_W  = 16;
  localparam int COUNT_W  = 32;
  localparam int SUM_W    = 47;
  localparam int ROOT_W   = 32;

  // Accumulator reset values.
  localparam logic [SAMPLE_W-1:0] MIN_RESET = 20'h7FFFF;
  localparam logic [SAMPLE_W-1:0] MAX_RESET = 20'h80000;

  // Back-end iteration counts: one quotient bit and one root bit per cycle.
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ_LOAD,
    ST_SQRT,
    ST_FIN
  } pfrm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic sq_load;
    logic sq_step;
    logic pend_load;
  } pfrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_last;
    logic out_free;
  } pfrm_sts_t;

endpackage

// ----- hw/rtl/pfrm_if.sv -----
// Request channel interfaces for raw words in and meter results out.
interface pfrm_in_if;
  import pfrm_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink (input valid, input raw_word, output ready);
endinterface

interface pfrm_out_if;
  import pfrm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SCALED_W-1:0] scaled_sample;
  logic [IDX_W-1:0]           sample_index;
  logic                       in_window;
  logic                       frame_done;
  logic [LEVEL_W-1:0]         rms_level;
  logic [LEVEL_W-1:0]         peak_to_peak;
  logic [COUNT_W-1:0]         frame_count;

  modport source (output valid, output scaled_sample, output sample_index, output in_window,
                  output frame_done, output rms_level, output peak_to_peak,
                  output frame_count, input ready);
  modport sink (input valid, input scaled_sample, input sample_index, input in_window,
                input frame_done, input rms_level, input peak_to_peak,
                input frame_count, output ready);
endinterface

// ----- hw/rtl/pfrm_ctrl.sv -----
// Controller state machine: request acceptance and sequencing of divide and root.
module pfrm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfrm_pkg::pfrm_sts_t sts,
  output pfrm_pkg::pfrm_cmd_t cmd
);
  import pfrm_pkg::*;

  pfrm_state_t       state_r;
  pfrm_state_t       state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and step count.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.out_free && sts.is_last) begin
          state_nxt = ST_DIV;
          step_nxt  = STEP_W'(DIV_STEPS - 1);
        end
      end
      ST_DIV: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_SQ_LOAD;
        end
      end
      ST_SQ_LOAD: begin
        state_nxt = ST_SQRT;
        step_nxt  = STEP_W'(ROOT_STEPS - 1);
      end
      ST_SQRT: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands decoded from the current state.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_SQ_LOAD: begin
        cmd.sq_load = 1'b1;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
      end
      ST_FIN: begin
        cmd.pend_load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A frame's last sample always starts the divider.
  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.is_last |=> state_r == ST_DIV)
    else $error("last sample did not start the divider");

  // The divider runs its full count before the root is loaded.
  a_div_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r == '0 |=> state_r == ST_SQ_LOAD)
    else $error("divider did not hand over to the root unit");

  // The root is only loaded straight out of the divider.
  a_root_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQ_LOAD |-> $past(state_r) == ST_DIV)
    else $error("root loaded without a finished division");

endmodule

// ----- hw/rtl/pfrm_dp.sv -----
// Datapath: sample scaling, frame accumulators, divider, root unit and result register.
module pfrm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pfrm_pkg::pfrm_cmd_t                  cmd,
  output pfrm_pkg::pfrm_sts_t                  sts,
  input  logic [pfrm_pkg::RAW_W-1:0]           raw_word,
  input  logic                                 cfg_we,
  input  logic [pfrm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pfrm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [pfrm_pkg::SCALED_W-1:0] out_scaled_sample,
  output logic [pfrm_pkg::IDX_W-1:0]           out_sample_index,
  output logic                                 out_in_window,
  output logic                                 out_frame_done,
  output logic [pfrm_pkg::LEVEL_W-1:0]         out_rms_level,
  output logic [pfrm_pkg::LEVEL_W-1:0]         out_peak_to_peak,
  output logic [pfrm_pkg::COUNT_W-1:0]         out_frame_count
);
  import pfrm_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] frame_len_r;
  logic [CFG_DATA_W-1:0] wave_pts_r;

  // Frame accumulators and held levels.
  logic [IDX_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic [SUM_W-1:0]           sum_r;
  logic [LEVEL_W-1:0]         last_rms_r;
  logic [LEVEL_W-1:0]         last_peak_r;
  logic [COUNT_W-1:0]         frames_r;

  // Result fields of a frame's last sample, held while the back end runs.
  logic signed [SCALED_W-1:0] pend_scaled_r;
  logic [IDX_W-1:0]           pend_idx_r;
  logic                       pend_win_r;

  // Divider and root unit.
  logic [SUM_W-1:0]      dvd_r;
  logic [IDX_W-1:0]      rem_r;
  logic [IDX_W-1:0]      dsr_r;
  logic [ROOT_W-1:0]     v_r;
  logic [ROOT_W-1:0]     g_r;
  logic [ROOT_W-1:0]     bit_r;

  // Result register.
  logic                       out_valid_r;
  logic signed [SCALED_W-1:0] out_scaled_r;
  logic [IDX_W-1:0]           out_idx_r;
  logic                       out_win_r;
  logic                       out_done_r;
  logic [LEVEL_W-1:0]         out_rms_r;
  logic [LEVEL_W-1:0]         out_peak_r;
  logic [COUNT_W-1:0]         out_count_r;

  // Per-sample combinational values.
  logic signed [SAMPLE_W-1:0]   ext;
  logic signed [SCALED_W-1:0]   scaled;
  logic signed [2*SCALED_W-1:0] square;
  logic [SUM_W-1:0]             sum_add;
  logic [IDX_W-1:0]             len;
  logic                         is_last;
  logic                         win;
  logic signed [SAMPLE_W-1:0]   min_new;
  logic signed [SAMPLE_W-1:0]   max_new;
  logic [SAMPLE_W:0]            span;
  logic [IDX_W:0]               rem_sh;
  logic                         q_bit;
  logic [IDX_W-1:0]             rem_nxt;
  logic [ROOT_W-1:0]            trial;
  logic                         root_fit;

  // Sample scaling, square and frame bookkeeping.
  always_comb begin
    ext      = signed'(raw_word[SAMPLE_W-1:0]);
    scaled   = ext[SAMPLE_W-1:SAMPLE_W-SCALED_W];
    square   = scaled * scaled;
    sum_add  = sum_r + SUM_W'(square[2*SCALED_W-2:0]);
    len      = (frame_len_r == '0) ? IDX_W'(1) : frame_len_r;
    is_last  = cnt_r >= (len - 1'b1);
    win      = cnt_r < wave_pts_r;
    min_new  = (ext < min_r) ? ext : min_r;
    max_new  = (ext > max_r) ? ext : max_r;
    span     = {max_new[SAMPLE_W-1], max_new} - {min_new[SAMPLE_W-1], min_new};
  end

  // One restoring division step and one root step.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[SUM_W-1]};
    q_bit    = rem_sh >= {1'b0, dsr_r};
    rem_nxt  = q_bit ? IDX_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[IDX_W-1:0];
    trial    = g_r + bit_r;
    root_fit = v_r >= trial;
  end

  assign sts.is_last  = is_last;
  assign sts.out_free = !out_valid_r || out_ready;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= RST_FRAME_LENGTH;
      wave_pts_r  <= RST_WINDOW_LEN;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_LENGTH: frame_len_r <= cfg_wdata;
        CFG_WINDOW_LEN:   wave_pts_r  <= cfg_wdata;
        default:          frame_len_r <= frame_len_r;
      endcase
    end
  end

  // Frame accumulators, held levels and frame counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      sum_r       <= '0;
      last_rms_r  <= '0;
      last_peak_r <= '0;
      frames_r    <= '0;
    end else begin
      if (cmd.accept) begin
        if (is_last) begin
          cnt_r       <= '0;
          min_r       <= MIN_RESET;
          max_r       <= MAX_RESET;
          sum_r       <= '0;
          last_peak_r <= span[SAMPLE_W-1:SAMPLE_W-LEVEL_W];
          frames_r    <= frames_r + 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          min_r <= min_new;
          max_r <= max_new;
          sum_r <= sum_add;
        end
      end
      if (cmd.pend_load) begin
        last_rms_r <= g_r[LEVEL_W-1:0];
      end
    end
  end

  // Pending fields, divider and root unit registers.
  always_ff @(posedge clk) begin
    if (cmd.accept && is_last) begin
      pend_scaled_r <= scaled;
      pend_idx_r    <= cnt_r;
      pend_win_r    <= win;
      dvd_r         <= sum_add;
      rem_r         <= '0;
      dsr_r         <= len;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
    // Mean saturates at 32 bits before the root.
    if (cmd.sq_load) begin
      v_r   <= (|dvd_r[SUM_W-1:ROOT_W]) ? '1 : dvd_r[ROOT_W-1:0];
      g_r   <= '0;
      bit_r <= {2'b01, {(ROOT_W-2){1'b0}}};
    end
    if (cmd.sq_step) begin
      if (root_fit) begin
        v_r <= v_r - trial;
        g_r <= (g_r >> 1) + bit_r;
      end else begin
        g_r <= g_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.accept && !is_last) || cmd.pend_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: straight from the sample, or from the back end at frame end.
  always_ff @(posedge clk) begin
    if (cmd.accept && !is_last) begin
      out_scaled_r <= scaled;
      out_idx_r    <= cnt_r;
      out_win_r    <= win;
      out_done_r   <= 1'b0;
      out_rms_r    <= last_rms_r;
      out_peak_r   <= last_peak_r;
      out_count_r  <= frames_r;
    end else if (cmd.pend_load) begin
      out_scaled_r <= pend_scaled_r;
      out_idx_r    <= pend_idx_r;
      out_win_r    <= pend_win_r;
      out_done_r   <= 1'b1;
      out_rms_r    <= g_r[LEVEL_W-1:0];
      out_peak_r   <= last_peak_r;
      out_count_r  <= frames_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scaled_sample = out_scaled_r;
  assign out_sample_index  = out_idx_r;
  assign out_in_window     = out_win_r;
  assign out_frame_done    = out_done_r;
  assign out_rms_level     = out_rms_r;
  assign out_peak_to_peak  = out_peak_r;
  assign out_frame_count   = out_count_r;

  // Each completed frame advances the counter by exactly one.
  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && is_last |=> frames_r == $past(frames_r) + 1'b1)
    else $error("frame counter did not advance on a frame end");

  // The sample index restarts after a frame end.
  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && is_last |=> cnt_r == '0)
    else $error("sample index not cleared after frame end");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < dsr_r)
    else $error("divider remainder out of range");

endmodule

// ----- hw/rtl/pcm_frame_rms_peak_meter.sv -----
// A sample that does not end a frame has its result registered in the cycle after accept.
// A frame's last sample has its result after the divider steps, a root load, the root steps,
// the final load, which waits for a free result register, and the result register.
// Throughput: one request per cycle within a frame while the result register is free; after
// a frame's last request the divider and root unit block new requests until its result loads.
// Reset (rst_n, synchronous, active low) restores frame length 1600 and window length 1024,
// clears the accumulators, held levels and frame counter, and empties the result register.
module pcm_frame_rms_peak_meter (
  input  logic                            clk,
  input  logic                            rst_n,
  pfrm_in_if.sink                         in_ch,
  pfrm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pfrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pfrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfrm_pkg::*;

  pfrm_cmd_t cmd;
  pfrm_sts_t sts;
  logic      in_ready;

  // Sequencing of acceptance and the back-end computation.
  pfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Arithmetic, accumulators and result register.
  pfrm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .raw_word          (in_ch.raw_word),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_scaled_sample (out_ch.scaled_sample),
    .out_sample_index  (out_ch.sample_index),
    .out_in_window     (out_ch.in_window),
    .out_frame_done    (out_ch.frame_done),
    .out_rms_level     (out_ch.rms_level),
    .out_peak_to_peak  (out_ch.peak_to_peak),
    .out_frame_count   (out_ch.frame_count)
  );

endmodule
